@@ hdl/form_urlencoded_field_extract_top_assert.svh @@
// Assertion macros for the form-urlencoded field extractor.
// Included by the top level; expects clk and rst_n in scope.
`ifndef FORM_URLENCODED_FIELD_EXTRACT_TOP_ASSERT_SVH
`define FORM_URLENCODED_FIELD_EXTRACT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FUE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FUE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fue_pkg.sv @@
// Shared types, codes and decode helpers for the form-urlencoded field extractor.
// No dependencies; used by fue_step and the top level.
package fue_pkg;

  localparam int POS_W     = 5;
  localparam int CAP_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CAP  = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_ENC   = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_BAD_SET   = 3'd4;

  localparam logic [1:0] PCT_NONE = 2'd0;
  localparam logic [1:0] PCT_HIGH = 2'd1;
  localparam logic [1:0] PCT_LOW  = 2'd2;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [4:0] HEX_BAD    = 5'd16;
  localparam logic [4:0] HEX_ALPHA  = 5'd10;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t           parse_phase;
    logic             key_still_matches;
    logic [POS_W-1:0] key_position;
    logic [1:0]       percent_phase;
    logic [3:0]       high_nibble;
    logic [CAP_W-1:0] value_count;
    logic             status_sent;
  } state_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       is_final;
    logic [2:0] lookup_status;
  } out_item_t;

  localparam state_t STATE_RESET = '{
    parse_phase:       PH_KEY,
    key_still_matches: 1'b1,
    key_position:      '0,
    percent_phase:     PCT_NONE,
    high_nibble:       4'd0,
    value_count:       '0,
    status_sent:       1'b0
  };

  // Returns the digit value, or HEX_BAD when the byte is not a hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] h;
    h = HEX_BAD;
    if (c >= "0" && c <= "9") h = 5'(c - "0");
    else if (c >= "A" && c <= "F") h = 5'(c - "A") + HEX_ALPHA;
    else if (c >= "a" && c <= "f") h = 5'(c - "a") + HEX_ALPHA;
    return h;
  endfunction

  function automatic state_t new_pair(input state_t s);
    state_t r;
    r = s;
    r.parse_phase       = PH_KEY;
    r.key_still_matches = 1'b1;
    r.key_position      = '0;
    r.percent_phase     = PCT_NONE;
    r.high_nibble       = 4'd0;
    return r;
  endfunction

  function automatic logic full_match(input state_t s, input logic [POS_W-1:0] klen);
    return s.key_still_matches && (s.percent_phase == PCT_NONE) &&
           (s.key_position == klen);
  endfunction

  function automatic logic [2:0] end_status(input state_t s, input logic [POS_W-1:0] klen);
    logic [2:0] st;
    st = ST_NOT_FOUND;
    if (s.parse_phase == PH_KEY) begin
      st = full_match(s, klen) ? ST_FOUND : ST_NOT_FOUND;
    end else if (s.parse_phase == PH_VALUE) begin
      st = (s.percent_phase != PCT_NONE) ? ST_BAD_ENC : ST_FOUND;
    end
    return st;
  endfunction

endpackage

@@ hdl/fue_step.sv @@
// Next-state and result logic for one body byte of the field extractor.
// Depends on fue_pkg; purely combinational.
module fue_step
  import fue_pkg::*;
#(
  parameter int KEY_BYTES = 16
) (
  input  state_t                 cur,
  input  in_item_t               item,
  input  logic [KEY_BYTES*8-1:0] key,
  input  logic [POS_W-1:0]       key_length,
  input  logic [CAP_W-1:0]       out_capacity,
  output state_t                 nxt,
  output logic                   emit,
  output out_item_t              result
);

  logic [7:0] b;
  logic [4:0] hex;
  logic       dec_byte;
  logic       dec_bad;
  logic [7:0] dec_val;
  logic [1:0] dec_pct;
  logic [3:0] dec_high;
  logic [7:0] key_byte;
  logic       key_ok;
  logic       bad_setting;
  logic       done;
  logic       has;
  logic [2:0] st;
  logic [7:0] val;

  assign b   = item.body_byte;
  assign hex = hex_digit(b);

  // Form decoding of one byte: plus to space, percent escapes to an octet.
  always_comb begin
    dec_byte = 1'b0;
    dec_bad  = 1'b0;
    dec_val  = b;
    dec_pct  = PCT_NONE;
    dec_high = cur.high_nibble;
    if (cur.percent_phase != PCT_NONE) begin
      if (hex[4]) begin
        dec_bad = 1'b1;
      end else if (cur.percent_phase == PCT_HIGH) begin
        dec_high = hex[3:0];
        dec_pct  = PCT_LOW;
      end else begin
        dec_byte = 1'b1;
        dec_val  = {cur.high_nibble, hex[3:0]};
      end
    end else if (b == CH_PERCENT) begin
      dec_pct = PCT_HIGH;
    end else begin
      dec_byte = 1'b1;
      dec_val  = (b == CH_PLUS) ? CH_SPACE : b;
    end
  end

  always_comb begin
    key_byte = 8'd0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (cur.key_position == POS_W'(i)) key_byte = key[8*i +: 8];
    end
  end

  assign key_ok = (cur.key_position < key_length) &&
                  (cur.key_position < POS_W'(KEY_BYTES)) && (key_byte == dec_val);

  assign bad_setting = (key_length == '0) || (key_length > POS_W'(KEY_BYTES)) ||
                       (out_capacity == '0);

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    has  = 1'b0;
    st   = ST_FOUND;
    val  = 8'd0;
    if (!cur.status_sent) begin
      if (bad_setting) begin
        done = 1'b1;
        st   = ST_BAD_SET;
      end else if (b == CH_NUL) begin
        done = 1'b1;
        st   = end_status(cur, key_length);
      end else begin
        unique case (cur.parse_phase)
          PH_KEY: begin
            if (b == CH_AMP) begin
              if (full_match(cur, key_length)) begin
                done = 1'b1;
                st   = ST_FOUND;
              end else begin
                nxt = new_pair(cur);
              end
            end else if (b == CH_EQUALS) begin
              if (full_match(cur, key_length)) begin
                nxt.parse_phase   = PH_VALUE;
                nxt.percent_phase = PCT_NONE;
                nxt.value_count   = '0;
              end else begin
                nxt.parse_phase = PH_SKIP;
              end
            end else begin
              nxt.percent_phase = dec_pct;
              nxt.high_nibble   = dec_high;
              if (dec_bad) begin
                nxt.key_still_matches = 1'b0;
              end else if (dec_byte) begin
                if (key_ok) nxt.key_position = cur.key_position + POS_W'(1);
                else nxt.key_still_matches = 1'b0;
              end
            end
          end
          PH_VALUE: begin
            if (b == CH_AMP) begin
              done = 1'b1;
              st   = (cur.percent_phase != PCT_NONE) ? ST_BAD_ENC : ST_FOUND;
            end else begin
              nxt.percent_phase = dec_pct;
              nxt.high_nibble   = dec_high;
              if (dec_bad) begin
                done = 1'b1;
                st   = ST_BAD_ENC;
              end else if (dec_byte) begin
                // The value must leave room for a terminator within the capacity.
                if (({1'b0, cur.value_count} + (CAP_W+1)'(1)) >= {1'b0, out_capacity}) begin
                  done = 1'b1;
                  st   = ST_TOO_LONG;
                end else begin
                  has             = 1'b1;
                  val             = dec_val;
                  nxt.value_count = cur.value_count + CAP_W'(1);
                end
              end
            end
          end
          PH_SKIP: begin
            if (b == CH_AMP) nxt = new_pair(cur);
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
      if (!done && item.end_of_body) begin
        done = 1'b1;
        st   = end_status(nxt, key_length);
      end
      if (done) nxt.status_sent = 1'b1;
    end
    if (item.end_of_body) nxt = STATE_RESET;
  end

  assign emit                 = has | done;
  assign result.out_byte      = has ? val : 8'd0;
  assign result.has_byte      = has;
  assign result.is_final      = done;
  assign result.lookup_status = done ? st : ST_FOUND;

endmodule

@@ hdl/form_urlencoded_field_extract_top.sv @@
// Form-urlencoded field extractor: one body byte per request, result is
// registered. The result of an accepted byte appears in the cycle after it; one
// byte is accepted every cycle while the result register is empty or taken.
// Synchronous active-low reset clears the parse state, the key to zero, the
// key length to zero and the output capacity to one.
`include "form_urlencoded_field_extract_top_assert.svh"

module form_urlencoded_field_extract_top
  import fue_pkg::*;
#(
  parameter int KEY_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LOW_BYTES = CFG_W / 8;

  logic [KEY_BYTES*8-1:0] key_r;
  logic [POS_W-1:0]       key_length_r;
  logic [CAP_W-1:0]       out_capacity_r;
  state_t                 state_r;
  state_t                 state_nxt;
  logic                   emit;
  out_item_t              result;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  logic                   in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r          <= '0;
      key_length_r   <= '0;
      out_capacity_r <= CAP_W'(1);
    end else if (cfg_we) begin
      for (int i = 0; i < KEY_BYTES; i++) begin
        if (i < LOW_BYTES) begin
          if (cfg_index == REG_KEY_LOW) key_r[8*i +: 8] <= cfg_data[8*i +: 8];
        end else begin
          if (cfg_index == REG_KEY_HIGH) key_r[8*i +: 8] <= cfg_data[8*(i-LOW_BYTES) +: 8];
        end
      end
      if (cfg_index == REG_KEY_LEN) key_length_r <= cfg_data[POS_W-1:0];
      if (cfg_index == REG_OUT_CAP) out_capacity_r <= cfg_data[CAP_W-1:0];
    end
  end

  fue_step #(
    .KEY_BYTES(KEY_BYTES)
  ) u_step (
    .cur          (state_r),
    .item         (in_data),
    .key          (key_r),
    .key_length   (key_length_r),
    .out_capacity (out_capacity_r),
    .nxt          (state_nxt),
    .emit         (emit),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FUE_ASSERT_NOW(a_result_not_empty, out_valid && !out_data.is_final, out_data.has_byte, "result without byte or status")
  `FUE_ASSERT_NOW(a_status_only_final, out_valid && !out_data.is_final, out_data.lookup_status == ST_FOUND, "status code on non-final result")
  `FUE_ASSERT_NEXT(a_quiet_after_status, in_fire && state_r.status_sent, !out_valid, "result after the status was sent")
  `FUE_ASSERT_NEXT(a_restart_at_end, in_fire && in_data.end_of_body, !state_r.status_sent && state_r.parse_phase == PH_KEY, "state not restarted after end of body")

endmodule
